FILE: sv/lpmr_pkg.sv
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared constants, types and helpers for the length-prefixed message ring.
// ----------------------------------------------------------------------------
package lpmr_pkg;

	localparam int STORE_BYTES = 4096;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int CNT_W       = $clog2(STORE_BYTES + 2);
	localparam int SUM_W       = CNT_W + 1;
	localparam int HDR_BYTES   = 4;
	localparam int HDR_W       = 32;
	localparam int LEN_W       = 13;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [2:0]        req_code_t;
	typedef logic [1:0]        status_t;

	localparam req_code_t REQ_PUSH = 3'd0;
	localparam req_code_t REQ_POP  = 3'd1;
	localparam req_code_t REQ_PEEK = 3'd2;
	localparam req_code_t REQ_DROP = 3'd3;
	localparam req_code_t REQ_PLEN = 3'd4;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_EMPTY   = 2'd1;
	localparam status_t ST_BAD_LEN = 2'd2;
	localparam status_t ST_REJECT  = 2'd3;

	typedef struct packed {
		logic       wr_en;
		addr_t      wr_addr;
		logic [7:0] wr_data;
		status_t    status;
		logic       msg_end;
		len_t       msg_length;
		logic       commit;
		cnt_t       commit_len;
	} push_res_t;

	function automatic addr_t wrap_add(addr_t a, cnt_t b);
		logic [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		if (s >= SUM_W'(STORE_BYTES))
			s = s - SUM_W'(STORE_BYTES);
		return ADDR_W'(s);
	endfunction

endpackage

FILE: sv/lpmr_req_if.sv
// ----------------------------------------------------------------------------
// lpmr_req_if
// Request channel: valid/ready handshake carrying one request transaction.
// ----------------------------------------------------------------------------
interface lpmr_req_if import lpmr_pkg::*; ();
	logic       valid;
	logic       ready;
	req_code_t  req_type;
	logic [7:0] data_byte;
	logic       push_end;

	modport source (output valid, req_type, data_byte, push_end, input ready);
	modport sink   (input valid, req_type, data_byte, push_end, output ready);
endinterface

FILE: sv/lpmr_rsp_if.sv
// ----------------------------------------------------------------------------
// lpmr_rsp_if
// Response channel: valid/ready handshake carrying one result transaction.
// ----------------------------------------------------------------------------
interface lpmr_rsp_if import lpmr_pkg::*; ();
	logic       valid;
	logic       ready;
	status_t    status;
	logic [7:0] read_byte;
	logic       msg_end;
	len_t       msg_length;
	len_t       used_bytes;

	modport source (output valid, status, read_byte, msg_end, msg_length, used_bytes,
		input ready);
	modport sink   (input valid, status, read_byte, msg_end, msg_length, used_bytes,
		output ready);
endinterface

FILE: sv/length_prefixed_message_ring_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_unit
// Byte ring store of whole messages with a 4-byte little-endian length prefix.
// ----------------------------------------------------------------------------
// One request transaction is worked at a time; the next one is taken while
// the previous result still waits in the output register. A pop or peek byte
// inside a message needs one read of the byte memory. A pop or peek at the
// start of a message, a drop and a peek-length make four header reads through
// the single read port of the byte memory; on an empty or short store they
// make none. No clearing pass is needed after reset.
module length_prefixed_message_ring_unit import lpmr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	lpmr_req_if.sink      req,
	lpmr_rsp_if.source    rsp
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_RDAT = 5'b00100,
		S_HDR  = 5'b01000,
		S_HCHK = 5'b10000
	} state_t;

	state_t state_q, state_n;

	req_code_t  req_type_q;
	logic [7:0] data_q;
	logic       end_q;

	addr_t write_ptr_q, write_ptr_n;
	addr_t read_ptr_q, read_ptr_n;
	addr_t read_cursor_q, read_cursor_n;
	cnt_t  read_rem_q, read_rem_n;
	cnt_t  used_q, used_n;

	logic [2:0]       hcnt_q, hcnt_n;
	addr_t            haddr_q, haddr_n;
	logic [HDR_W-1:0] hdr_q;

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rdata_q;
	logic       rd_en;
	addr_t      rd_addr;

	logic       out_valid_q;
	status_t    out_status_q;
	logic [7:0] out_byte_q;
	logic       out_end_q;
	len_t       out_len_q;

	logic       fin, fin_ok, push_step;
	status_t    res_status;
	logic [7:0] res_byte;
	logic       res_end;
	len_t       res_len;

	push_res_t pres;

	lpmr_push u_push (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (push_step),
		.data_byte (data_q),
		.push_end  (end_q),
		.write_ptr (write_ptr_q),
		.used      (used_q),
		.res       (pres)
	);

	assign req.ready = (state_q == S_IDLE);
	assign fin_ok    = !out_valid_q || rsp.ready;

	always_comb begin
		logic             bad;
		cnt_t             hlen, done, mlen_full, rem_dec;
		addr_t            nptr;
		state_n       = state_q;
		write_ptr_n   = write_ptr_q;
		read_ptr_n    = read_ptr_q;
		read_cursor_n = read_cursor_q;
		read_rem_n    = read_rem_q;
		used_n        = used_q;
		hcnt_n        = hcnt_q;
		haddr_n       = haddr_q;
		rd_en         = 1'b0;
		rd_addr       = read_cursor_q;
		fin           = 1'b0;
		push_step     = 1'b0;
		res_status    = ST_OK;
		res_byte      = '0;
		res_end       = 1'b0;
		res_len       = '0;
		bad           = (hdr_q < HDR_W'(HDR_BYTES)) || (hdr_q > HDR_W'(used_q));
		hlen          = CNT_W'(hdr_q);
		done          = CNT_W'(read_cursor_q) - CNT_W'(read_ptr_q) +
			((read_cursor_q < read_ptr_q) ? CNT_W'(STORE_BYTES) : '0);
		mlen_full     = done + read_rem_q;
		rem_dec       = read_rem_q - CNT_W'(1);
		nptr          = '0;

		case (state_q)
			S_IDLE: begin
				if (req.valid)
					state_n = S_EXEC;
			end
			S_EXEC: begin
				if (req_type_q == REQ_PUSH) begin
					if (fin_ok) begin
						fin        = 1'b1;
						push_step  = 1'b1;
						res_status = pres.status;
						res_end    = pres.msg_end;
						res_len    = pres.msg_length;
						if (pres.commit) begin
							write_ptr_n = wrap_add(write_ptr_q, pres.commit_len);
							used_n      = used_q + pres.commit_len;
						end
						state_n = S_IDLE;
					end
				end else if (req_type_q inside {REQ_POP, REQ_PEEK} && read_rem_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = read_cursor_q;
					state_n = S_RDAT;
				end else if (req_type_q inside {REQ_POP, REQ_PEEK, REQ_DROP, REQ_PLEN}) begin
					if (used_q < CNT_W'(HDR_BYTES)) begin
						if (fin_ok) begin
							fin        = 1'b1;
							res_end    = 1'b1;
							res_status = (used_q == '0) ? ST_EMPTY : ST_BAD_LEN;
							if (req_type_q == REQ_DROP) begin
								read_rem_n    = '0;
								read_cursor_n = read_ptr_q;
							end
							state_n = S_IDLE;
						end
					end else begin
						hcnt_n  = '0;
						haddr_n = read_ptr_q;
						state_n = S_HDR;
					end
				end else if (fin_ok) begin
					fin     = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_HDR: begin
				if (hcnt_q < 3'(HDR_BYTES)) begin
					rd_en   = 1'b1;
					rd_addr = haddr_q;
					haddr_n = wrap_add(haddr_q, CNT_W'(1));
					hcnt_n  = hcnt_q + 3'd1;
				end else begin
					state_n = S_HCHK;
				end
			end
			S_HCHK: begin
				if (fin_ok) begin
					fin     = 1'b1;
					state_n = S_IDLE;
					case (req_type_q)
						REQ_POP, REQ_PEEK: begin
							if (bad) begin
								res_status = ST_BAD_LEN;
								res_end    = 1'b1;
							end else begin
								res_byte      = hdr_q[7:0];
								res_len       = LEN_W'(hlen);
								read_cursor_n = wrap_add(read_ptr_q, CNT_W'(1));
								read_rem_n    = hlen - CNT_W'(1);
							end
						end
						REQ_DROP: begin
							res_end    = 1'b1;
							read_rem_n = '0;
							if (bad) begin
								res_status    = ST_BAD_LEN;
								read_cursor_n = read_ptr_q;
							end else begin
								nptr          = wrap_add(read_ptr_q, hlen);
								read_ptr_n    = nptr;
								read_cursor_n = nptr;
								used_n        = used_q - hlen;
								res_len       = LEN_W'(hlen);
							end
						end
						REQ_PLEN: begin
							res_end = 1'b1;
							if (bad)
								res_status = ST_BAD_LEN;
							else
								res_len = LEN_W'(hlen);
						end
						default: begin
							res_end = 1'b0;
						end
					endcase
				end
			end
			S_RDAT: begin
				if (fin_ok) begin
					fin        = 1'b1;
					state_n    = S_IDLE;
					res_byte   = rdata_q;
					res_len    = LEN_W'(mlen_full);
					read_rem_n = rem_dec;
					if (rem_dec == '0) begin
						res_end = 1'b1;
						if (req_type_q == REQ_POP) begin
							nptr          = wrap_add(read_ptr_q, mlen_full);
							read_ptr_n    = nptr;
							read_cursor_n = nptr;
							used_n        = used_q - mlen_full;
						end else begin
							read_cursor_n = read_ptr_q;
						end
					end else begin
						read_cursor_n = wrap_add(read_cursor_q, CNT_W'(1));
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push_step && pres.wr_en)
			mem[pres.wr_addr] <= pres.wr_data;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_q <= req.req_type;
			data_q     <= req.data_byte;
			end_q      <= req.push_end;
		end
		if (state_q == S_HDR && hcnt_q != '0)
			hdr_q <= {rdata_q, hdr_q[HDR_W-1:8]};
		if (fin) begin
			out_status_q <= res_status;
			out_byte_q   <= res_byte;
			out_end_q    <= res_end;
			out_len_q    <= res_len;
		end
		haddr_q <= haddr_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			write_ptr_q   <= '0;
			read_ptr_q    <= '0;
			read_cursor_q <= '0;
			read_rem_q    <= '0;
			used_q        <= '0;
			hcnt_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_n;
			write_ptr_q   <= write_ptr_n;
			read_ptr_q    <= read_ptr_n;
			read_cursor_q <= read_cursor_n;
			read_rem_q    <= read_rem_n;
			used_q        <= used_n;
			hcnt_q        <= hcnt_n;
			if (fin)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_byte  = out_byte_q;
	assign rsp.msg_end    = out_end_q;
	assign rsp.msg_length = out_len_q;
	assign rsp.used_bytes = LEN_W'(used_q);

`ifndef SYNTHESIS
	a_rem_within_used: assert property (@(posedge clk) disable iff (!arst_n)
		read_rem_q <= used_q)
		else $error("read in progress extends past committed bytes");

	a_ok_end_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_end_q && out_status_q == ST_OK |-> out_len_q >= LEN_W'(HDR_BYTES))
		else $error("completed message shorter than its header");

	a_ptr_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!fin |=> $stable(read_ptr_q) && $stable(write_ptr_q) && $stable(used_q))
		else $error("ring pointers moved without a result");
`endif

endmodule

FILE: sv/lpmr_push.sv
// ----------------------------------------------------------------------------
// lpmr_push
// Push assembler: tracks the message being pushed, collects its header,
// decides byte writes, rejection and commit.
// ----------------------------------------------------------------------------
module lpmr_push import lpmr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       push_end,
	input  addr_t      write_ptr,
	input  cnt_t       used,
	output push_res_t  res
);

	cnt_t             count_q, count_n;
	addr_t            cursor_q, cursor_n;
	logic [HDR_W-1:0] hdr_q, hdr_n;
	logic             rej_q, rej_n;

	always_comb begin
		cnt_t free_b;
		logic first;
		first  = (count_q == '0);
		free_b = CNT_W'(STORE_BYTES) - used;

		cursor_n = first ? write_ptr : cursor_q;
		hdr_n    = first ? '0 : hdr_q;
		rej_n    = first ? 1'b0 : rej_q;
		count_n  = count_q;
		res      = '0;
		res.wr_data = data_byte;
		res.wr_addr = cursor_n;

		if (!rej_n) begin
			if (count_q < free_b) begin
				res.wr_en = 1'b1;
				cursor_n  = wrap_add(cursor_n, CNT_W'(1));
			end else begin
				rej_n = 1'b1;
			end
		end
		if (count_q < CNT_W'(HDR_BYTES))
			hdr_n[{count_q[1:0], 3'b000} +: 8] = data_byte;
		if (count_q <= CNT_W'(STORE_BYTES))
			count_n = count_q + CNT_W'(1);
		if (count_n >= CNT_W'(HDR_BYTES)) begin
			if (hdr_n < HDR_W'(HDR_BYTES) || hdr_n > HDR_W'(free_b) ||
				HDR_W'(count_n) > hdr_n)
				rej_n = 1'b1;
			res.msg_length = LEN_W'(hdr_n);
		end
		if (push_end) begin
			res.msg_end = 1'b1;
			if (!rej_n && count_n >= CNT_W'(HDR_BYTES) && HDR_W'(count_n) == hdr_n) begin
				res.commit     = 1'b1;
				res.commit_len = CNT_W'(hdr_n);
			end else begin
				res.status = ST_REJECT;
			end
			count_n = '0;
			rej_n   = 1'b0;
		end else if (rej_n) begin
			res.status = ST_REJECT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			hdr_q    <= '0;
			rej_q    <= 1'b0;
		end else if (step) begin
			count_q  <= count_n;
			cursor_q <= cursor_n;
			hdr_q    <= hdr_n;
			rej_q    <= rej_n;
		end
	end

endmodule

FILE: bench/length_prefixed_message_ring_unit_test.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_unit_test
// Checks the message ring against a cycle-free predictor of its store. The
// run goes through fixed corner cases, then holds the result side off while
// requests keep coming, then runs random message traffic.
// Both handshakes idle at random, and every result is compared in order.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_unit_test import lpmr_pkg::*; ;

	localparam int          MAX_GAP          = 6;
	localparam int          RSP_HOLD_CYCLES  = 300;
	localparam int          STALL_LIMIT      = 2000;
	localparam int          TAIL_CYCLES      = 20;
	localparam int          RANDOM_ITEMS     = 1720;
	localparam int          SHOWN_MISMATCHES = 10;
	localparam req_code_t   REQ_UNUSED_HI    = '1;

	typedef struct packed {
		status_t    status;
		logic [7:0] read_byte;
		logic       msg_end;
		len_t       msg_length;
		len_t       used_bytes;
	} ring_result_t;

	class message_ring_checker;
		bit [7:0]     ring_bytes [STORE_BYTES];
		addr_t        wr_ptr = '0, rd_ptr = '0, push_at = '0, rd_at = '0;
		cnt_t         used = '0, push_cnt = '0, rd_left = '0;
		logic [31:0]  push_hdr = '0;
		bit           push_bad;
		ring_result_t pending_results[$];
		int           errors;

		function addr_t advance(addr_t p, int unsigned n);
			return addr_t'((p + n) % STORE_BYTES);
		endfunction

		function status_t head_check(output int unsigned len);
			logic [31:0] h;
			len = 0;
			if (used == 0)
				return ST_EMPTY;
			if (used < HDR_BYTES)
				return ST_BAD_LEN;
			for (int i = 0; i < HDR_BYTES; i++)
				h[8*i +: 8] = ring_bytes[advance(rd_ptr, i)];
			if (h < HDR_BYTES || h > used)
				return ST_BAD_LEN;
			len = h;
			return ST_OK;
		endfunction

		function int unsigned head_length();
			int unsigned len;
			void'(head_check(len));
			return len;
		endfunction

		function ring_result_t predict(req_code_t code, logic [7:0] data, logic last);
			ring_result_t r;
			cnt_t         free_bytes;
			int unsigned  len, done, span;
			bit           go;
			r = '0;
			case (code)
				REQ_PUSH: begin
					free_bytes = cnt_t'(STORE_BYTES - used);
					if (push_cnt == 0) begin
						push_at  = wr_ptr;
						push_hdr = '0;
						push_bad = 1'b0;
					end
					if (!push_bad) begin
						if (push_cnt < free_bytes) begin
							ring_bytes[push_at] = data;
							push_at = advance(push_at, 1);
						end else begin
							push_bad = 1'b1;
						end
					end
					if (push_cnt < HDR_BYTES)
						push_hdr[8*push_cnt +: 8] = data;
					if (push_cnt <= STORE_BYTES)
						push_cnt++;
					if (push_cnt >= HDR_BYTES) begin
						if (push_hdr < HDR_BYTES || push_hdr > free_bytes || push_cnt > push_hdr)
							push_bad = 1'b1;
						r.msg_length = len_t'(push_hdr);
					end
					if (last) begin
						r.msg_end = 1'b1;
						if (!push_bad && push_cnt >= HDR_BYTES && push_cnt == push_hdr) begin
							wr_ptr = advance(wr_ptr, push_hdr);
							used += cnt_t'(push_hdr);
						end else begin
							r.status = ST_REJECT;
						end
						push_cnt = 0;
						push_bad = 1'b0;
						push_at  = wr_ptr;
					end else if (push_bad) begin
						r.status = ST_REJECT;
					end
				end
				REQ_POP, REQ_PEEK: begin
					go = 1'b1;
					if (rd_left == 0) begin
						r.status = head_check(len);
						if (r.status != ST_OK) begin
							r.msg_end = 1'b1;
							go = 1'b0;
						end else begin
							rd_at   = rd_ptr;
							rd_left = cnt_t'(len);
						end
					end
					if (go) begin
						done = (rd_at + STORE_BYTES - rd_ptr) % STORE_BYTES;
						span = done + rd_left;
						r.msg_length = len_t'(span);
						r.read_byte  = ring_bytes[rd_at];
						rd_at = advance(rd_at, 1);
						rd_left--;
						if (rd_left == 0) begin
							r.msg_end = 1'b1;
							if (code == REQ_POP) begin
								rd_ptr = advance(rd_ptr, span);
								used -= cnt_t'(span);
							end
							rd_at = rd_ptr;
						end
					end
				end
				REQ_DROP: begin
					r.msg_end = 1'b1;
					r.status  = head_check(len);
					rd_left   = 0;
					if (r.status == ST_OK) begin
						rd_ptr = advance(rd_ptr, len);
						used -= cnt_t'(len);
						r.msg_length = len_t'(len);
					end
					rd_at = rd_ptr;
				end
				REQ_PLEN: begin
					r.msg_end    = 1'b1;
					r.status     = head_check(len);
					r.msg_length = len_t'(len);
				end
				default: ;
			endcase
			r.used_bytes = len_t'(used);
			return r;
		endfunction

		function void note_request(req_code_t code, logic [7:0] data, logic last);
			pending_results.push_back(predict(code, data, last));
		endfunction

		function void check_result(ring_result_t got);
			ring_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= SHOWN_MISMATCHES)
					$display("unexpected result transaction: status %0d byte %02h end %0b",
						got.status, got.read_byte, got.msg_end,
						" len %0d used %0d", got.msg_length, got.used_bytes);
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.read_byte !== want.read_byte ||
					got.msg_end !== want.msg_end || got.msg_length !== want.msg_length ||
					got.used_bytes !== want.used_bytes) begin
				errors++;
				if (errors <= SHOWN_MISMATCHES) begin
					$display("mismatch: exp status %0d byte %02h end %0b len %0d used %0d",
						want.status, want.read_byte, want.msg_end, want.msg_length,
						want.used_bytes);
					$display("          got status %0d byte %02h end %0b len %0d used %0d",
						got.status, got.read_byte, got.msg_end, got.msg_length,
						got.used_bytes);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lpmr_req_if req_ch ();
	lpmr_rsp_if rsp_ch ();

	length_prefixed_message_ring_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	message_ring_checker ring_check = new();
	bit no_gaps;
	bit hold_rsp;
	int requests_sent;
	int quiet_cycles;

	always #5 clk = ~clk;

	task automatic send_request(req_code_t code, logic [7:0] data, logic last);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= code;
		req_ch.data_byte <= data;
		req_ch.push_end  <= last;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		ring_check.note_request(code, data, last);
		if (code <= REQ_PLEN)
			requests_sent++;
	endtask

	// header bytes carry hdr little-endian, the rest is random content
	task automatic push_message(logic [31:0] hdr, int unsigned count, bit ends);
		logic [7:0] b;
		for (int unsigned i = 0; i < count; i++) begin
			b = (i < HDR_BYTES) ? hdr[8*i +: 8] : 8'($urandom_range(0, 255));
			send_request(REQ_PUSH, b, ends && i == count - 1);
		end
	endtask

	task automatic read_bytes(req_code_t code, int unsigned count);
		repeat (count)
			send_request(code, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (ring_check.pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic int unsigned draw_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(25, 400);
		return $urandom_range(HDR_BYTES, 24);
	endfunction

	initial begin
		int unsigned gap;
		ring_result_t got;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end
			gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			got = '{rsp_ch.status, rsp_ch.read_byte, rsp_ch.msg_end, rsp_ch.msg_length,
				rsp_ch.used_bytes};
			ring_check.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int unsigned pick, whole, hdr, count, random_goal;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_PUSH;
		req_ch.data_byte <= '0;
		req_ch.push_end  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty store answers
		send_request(REQ_POP, 8'h00, 1'b0);
		send_request(REQ_DROP, 8'hFF, 1'b1);
		send_request(REQ_PLEN, 8'h00, 1'b0);
		// six-byte message with both byte extremes
		send_request(REQ_PUSH, 8'(HDR_BYTES + 2), 1'b0);
		send_request(REQ_PUSH, 8'h00, 1'b0);
		send_request(REQ_PUSH, 8'h00, 1'b0);
		send_request(REQ_PUSH, 8'h00, 1'b0);
		send_request(REQ_PUSH, 8'hFF, 1'b0);
		send_request(REQ_PUSH, 8'h00, 1'b1);
		send_request(REQ_PLEN, 8'hFF, 1'b1);
		// peek then pop on one cursor: the pop finishes and frees
		read_bytes(REQ_PEEK, 3);
		read_bytes(REQ_POP, 3);
		push_message(32'hFFFF_FFFF, HDR_BYTES, 1'b1);
		push_message(HDR_BYTES, 2, 1'b1);
		send_request(REQ_UNUSED_HI, 8'hFF, 1'b1);
		wait_drained();

		// results held off: the block fills and stalls its request side
		hold_rsp = 1'b1;
		push_message(HDR_BYTES, HDR_BYTES, 1'b1);
		send_request(REQ_PLEN, 8'h00, 1'b0);
		send_request(REQ_DROP, 8'h00, 1'b0);
		wait_drained();

		random_goal = requests_sent + RANDOM_ITEMS;
		while (requests_sent < random_goal) begin
			no_gaps = ($urandom_range(0, 5) == 0);
			pick = $urandom_range(0, 99);
			whole = (ring_check.rd_left != 0) ? ring_check.rd_left : ring_check.head_length();
			if (whole == 0)
				whole = 1;
			if (pick < 38 && ring_check.used < 3500) begin
				hdr = draw_length();
				push_message(hdr, hdr, 1'b1);
			end else if (pick < 56) begin
				read_bytes(REQ_POP, ($urandom_range(0, 2) == 0) ? $urandom_range(1, whole) : whole);
			end else if (pick < 68) begin
				read_bytes(REQ_PEEK, ($urandom_range(0, 2) == 0) ? $urandom_range(1, whole) : whole);
			end else if (pick < 76) begin
				send_request(REQ_DROP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (pick < 82) begin
				send_request(REQ_PLEN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (pick < 92) begin
				case ($urandom_range(0, 3))
					0: begin
						hdr = draw_length();
						push_message(hdr, $urandom_range(1, hdr + 3), 1'b1);
					end
					1: push_message($urandom_range(0, HDR_BYTES - 1), $urandom_range(1, 8), 1'b1);
					2: push_message($urandom(), $urandom_range(HDR_BYTES, 8), 1'b1);
					default: begin
						hdr = draw_length();
						push_message(hdr, $urandom_range(1, hdr), 1'b0);
					end
				endcase
			end else if (pick < 97) begin
				count = $urandom_range(1, 3);
				repeat (count)
					send_request(req_code_t'($urandom_range(REQ_PUSH, REQ_PLEN)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				send_request(req_code_t'($urandom_range(REQ_PLEN + 1, REQ_UNUSED_HI)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 99) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ring_check.errors == 0 && ring_check.pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
sv/lpmr_pkg.sv
sv/lpmr_req_if.sv
sv/lpmr_rsp_if.sv
sv/lpmr_push.sv
sv/length_prefixed_message_ring_unit.sv
bench/length_prefixed_message_ring_unit_test.sv
